FILE: hdl/swb_pkg.sv
// Package: shared types, codes and constants of the stopwatch bank.
`default_nettype none
package swb_pkg;

	localparam int SYSTEM_CLOCKS_DEF = 3;
	localparam int USER_CLOCKS_DEF   = 8;
	localparam int USER_ID_BASE_DEF  = 100;

	localparam logic [31:0] WRAP_HIGH   = 32'hF000_0001;
	localparam logic [31:0] WRAP_LOW    = 32'h1000_0000;
	localparam logic [31:0] SCALE_RESET = 32'd6152199;
	localparam logic [47:0] Q16_MAX     = 48'h7FFF_FFFF_FFFF;
	localparam logic [47:0] Q16_MIN     = 48'h8000_0000_0000;

	typedef enum logic [1:0] {
		OP_INIT  = 2'd0,
		OP_RESET = 2'd1,
		OP_READ  = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DIFF,
		ST_MAG,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic capture;
		logic exec;
		logic diff;
		logic mag;
		logic mul_lo;
		logic mul_hi;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic read_known;
		logic out_busy;
	} status_t;

endpackage
`default_nettype wire

FILE: hdl/swb_ifs.sv
// Interfaces: request, response and configuration channels.
`default_nettype none
interface swb_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [7:0]  clock_id;
	logic [31:0] count_sample;
	modport source (output valid, opcode, clock_id, count_sample, input ready);
	modport sink (input valid, opcode, clock_id, count_sample, output ready);
endinterface

interface swb_rsp_if;
	logic               valid;
	logic               ready;
	logic               id_known;
	logic signed [63:0] elapsed_ticks;
	logic signed [47:0] elapsed_seconds_q16;
	logic               seconds_saturated;
	modport source (output valid, id_known, elapsed_ticks, elapsed_seconds_q16,
		seconds_saturated, input ready);
	modport sink (input valid, id_known, elapsed_ticks, elapsed_seconds_q16,
		seconds_saturated, output ready);
endinterface

interface swb_cfg_if;
	logic        valid;
	logic        ready;
	logic [31:0] seconds_scale;
	modport source (output valid, seconds_scale, input ready);
	modport sink (input valid, seconds_scale, output ready);
endinterface
`default_nettype wire

FILE: hdl/swb_ctrl.sv
// Controller: sequences one transaction through the datapath.
`default_nettype none
module swb_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             req_valid,
	output logic                  req_ready,
	input  wire swb_pkg::status_t sts,
	output swb_pkg::cmd_t         cmd
);

	swb_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= swb_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			swb_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d     = swb_pkg::ST_EXEC;
				end
			end
			swb_pkg::ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = sts.read_known ? swb_pkg::ST_DIFF : swb_pkg::ST_FINISH;
			end
			swb_pkg::ST_DIFF: begin
				cmd.diff = 1'b1;
				state_d  = swb_pkg::ST_MAG;
			end
			swb_pkg::ST_MAG: begin
				cmd.mag = 1'b1;
				state_d = swb_pkg::ST_MUL_LO;
			end
			swb_pkg::ST_MUL_LO: begin
				cmd.mul_lo = 1'b1;
				state_d    = swb_pkg::ST_MUL_HI;
			end
			swb_pkg::ST_MUL_HI: begin
				cmd.mul_hi = 1'b1;
				state_d    = swb_pkg::ST_FINISH;
			end
			swb_pkg::ST_FINISH: begin
				if (!sts.out_busy) begin
					cmd.finish = 1'b1;
					state_d    = swb_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = swb_pkg::ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

FILE: hdl/swb_dp.sv
// Datapath: count tracking, stopwatch marks, tick and seconds arithmetic.
`default_nettype none
module swb_dp #(
	parameter int SYSTEM_CLOCKS = swb_pkg::SYSTEM_CLOCKS_DEF,
	parameter int USER_CLOCKS   = swb_pkg::USER_CLOCKS_DEF,
	parameter int USER_ID_BASE  = swb_pkg::USER_ID_BASE_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	swb_req_if.sink             req,
	swb_rsp_if.source           rsp,
	swb_cfg_if.sink             cfg,
	input  wire swb_pkg::cmd_t  cmd,
	output swb_pkg::status_t    sts
);

	localparam int NUM_WATCHES = SYSTEM_CLOCKS + USER_CLOCKS;
	localparam int SW = (NUM_WATCHES > 1) ? $clog2(NUM_WATCHES) : 1;

	// request capture and slot decode
	logic [8:0]    id9;
	logic [SW-1:0] slot_d;
	logic          known_d;

	always_comb begin
		id9     = {1'b0, req.clock_id};
		slot_d  = '0;
		known_d = 1'b0;
		if (id9 < 9'(SYSTEM_CLOCKS)) begin
			slot_d  = SW'(id9);
			known_d = 1'b1;
		end else if (id9 >= 9'(USER_ID_BASE) && id9 < 9'(USER_ID_BASE + USER_CLOCKS)) begin
			slot_d  = SW'(id9 - 9'(USER_ID_BASE) + 9'(SYSTEM_CLOCKS));
			known_d = 1'b1;
		end
	end

	logic [1:0]    op_q;
	logic [SW-1:0] slot_q;
	logic          known_q;
	logic [31:0]   sample_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			known_q <= 1'b0;
			op_q    <= swb_pkg::OP_INIT;
		end else if (cmd.capture) begin
			known_q <= known_d;
			op_q    <= req.opcode;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			slot_q   <= slot_d;
			sample_q <= req.count_sample;
		end
	end

	// configuration
	logic [31:0] scale_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= swb_pkg::SCALE_RESET;
		end else if (cfg.valid) begin
			scale_q <= cfg.seconds_scale;
		end
	end

	// count tracking and marks
	logic [31:0] last_q, wrap_q, wrap_upd;
	logic [31:0] mark_count_q [NUM_WATCHES];
	logic [31:0] mark_wraps_q [NUM_WATCHES];
	logic        read_known;

	assign read_known = (op_q == swb_pkg::OP_READ) && known_q;
	assign wrap_upd   = (last_q >= swb_pkg::WRAP_HIGH && sample_q < swb_pkg::WRAP_LOW) ?
		wrap_q + 32'd1 : wrap_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
			wrap_q <= '0;
			for (int i = 0; i < NUM_WATCHES; i++) begin
				mark_count_q[i] <= '0;
				mark_wraps_q[i] <= '0;
			end
		end else if (cmd.exec) begin
			case (op_q)
				swb_pkg::OP_INIT: begin
					last_q <= sample_q;
					wrap_q <= '0;
				end
				swb_pkg::OP_RESET: begin
					last_q <= sample_q;
					wrap_q <= wrap_upd;
					if (known_q) begin
						mark_count_q[slot_q] <= sample_q;
						mark_wraps_q[slot_q] <= wrap_upd;
					end
				end
				swb_pkg::OP_READ: begin
					if (known_q) begin
						last_q <= sample_q;
						wrap_q <= wrap_upd;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// differences, signed ticks and magnitude
	logic [31:0] wd_q;
	logic [32:0] cd_q;
	logic [63:0] ut, ut_q, mag_q;
	logic        neg, neg_q;

	assign ut  = {wd_q - {31'd0, cd_q[32]}, cd_q[31:0]};
	assign neg = wd_q[31] || (wd_q == 32'd0 && cd_q[32]);

	always_ff @(posedge clk) begin
		if (cmd.diff) begin
			wd_q <= wrap_q - mark_wraps_q[slot_q];
			cd_q <= {1'b0, last_q} - {1'b0, mark_count_q[slot_q]};
		end
		if (cmd.mag) begin
			ut_q  <= ut;
			neg_q <= neg;
			mag_q <= neg ? (64'd0 - ut) : ut;
		end
	end

	// shared 32x32 scale multiplier
	logic [31:0] mul_a;
	logic [63:0] prod, plo_q, phi_q;

	assign mul_a = cmd.mul_hi ? mag_q[63:32] : mag_q[31:0];
	assign prod  = {32'd0, mul_a} * {32'd0, scale_q};

	always_ff @(posedge clk) begin
		if (cmd.mul_lo) begin
			plo_q <= prod;
		end
		if (cmd.mul_hi) begin
			phi_q <= prod;
		end
	end

	// round toward minus infinity, saturate
	logic [64:0] q;
	logic [47:0] sec;
	logic        sat;

	always_comb begin
		q   = {1'b0, phi_q} + {33'd0, plo_q[63:32]} +
			{64'd0, (neg_q && plo_q[31:0] != 32'd0)};
		sat = 1'b0;
		if (neg_q) begin
			if (q > {17'd0, swb_pkg::Q16_MAX} + 65'd1) begin
				sat = 1'b1;
				sec = swb_pkg::Q16_MIN;
			end else begin
				sec = 48'd0 - q[47:0];
			end
		end else if (q > {17'd0, swb_pkg::Q16_MAX}) begin
			sat = 1'b1;
			sec = swb_pkg::Q16_MAX;
		end else begin
			sec = q[47:0];
		end
	end

	// result register
	logic        rsp_valid_q, known_out_q, sat_q;
	logic [63:0] ticks_q;
	logic [47:0] sec_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			known_out_q <= known_q;
			ticks_q     <= read_known ? ut_q : 64'd0;
			sec_q       <= read_known ? sec : 48'd0;
			sat_q       <= read_known && sat;
		end
	end

	assign rsp.valid               = rsp_valid_q;
	assign rsp.id_known            = known_out_q;
	assign rsp.elapsed_ticks       = $signed(ticks_q);
	assign rsp.elapsed_seconds_q16 = $signed(sec_q);
	assign rsp.seconds_saturated   = sat_q;

	assign sts.read_known = read_known;
	assign sts.out_busy   = rsp_valid_q && !rsp.ready;

endmodule
`default_nettype wire

FILE: hdl/stopwatch_bank_with_wrap_tracking.sv
// Top level: stopwatch bank with 32-bit count wrap tracking.
//
// Channels: req carries one operation (opcode, clock_id, count_sample);
// rsp returns exactly one result per request transaction; cfg writes the
// seconds_scale register and is always ready. Write cfg only while idle.
// One request is in flight at a time; req.ready is high only while idle.
// Init, reset-stopwatch, opcode 3 and unknown-id reads pass through the
// exec and finish states before the result is loaded. Known-id reads add
// the diff and magnitude steps and two passes of the shared 32x32
// multiplier; the round/saturate step is combinational in the finish state.
// A new request is taken only after the previous one has returned to idle.
// The result sits in an output register, so the next request is taken
// while a result waits; if rsp stalls, a following request completes up
// to its final step and holds there until the register frees.
// Reset clears the count, wrap total and all stopwatch marks, restores
// seconds_scale to its default and empties the output register.
`default_nettype none
module stopwatch_bank_with_wrap_tracking #(
	parameter int SYSTEM_CLOCKS = swb_pkg::SYSTEM_CLOCKS_DEF,
	parameter int USER_CLOCKS   = swb_pkg::USER_CLOCKS_DEF,
	parameter int USER_ID_BASE  = swb_pkg::USER_ID_BASE_DEF
) (
	input wire logic  clk,
	input wire logic  arst_n,
	swb_req_if.sink   req,
	swb_rsp_if.source rsp,
	swb_cfg_if.sink   cfg
);

	swb_pkg::cmd_t    cmd;
	swb_pkg::status_t sts;
	logic             req_ready;

	assign req.ready = req_ready;

	swb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	swb_dp #(
		.SYSTEM_CLOCKS (SYSTEM_CLOCKS),
		.USER_CLOCKS   (USER_CLOCKS),
		.USER_ID_BASE  (USER_ID_BASE)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg),
		.cmd    (cmd),
		.sts    (sts)
	);

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request accepted while another is in flight");

	a_zero_unless_known: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.id_known |->
		rsp.elapsed_ticks == 64'sd0 && rsp.elapsed_seconds_q16 == 48'sd0 &&
		!rsp.seconds_saturated)
		else $error("nonzero result for unknown id");

	a_sat_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.seconds_saturated |->
		rsp.elapsed_seconds_q16 == $signed(swb_pkg::Q16_MAX) ||
		rsp.elapsed_seconds_q16 == $signed(swb_pkg::Q16_MIN))
		else $error("saturation flag without limit value");

endmodule
`default_nettype wire
